// ===== rtl/clcd_pkg.sv =====
`default_nettype none
package clcd_pkg;

	// Depth of the request queue between the front end and the sequencer.
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned HOLD_W = 20;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned STEP_W = 5;

	localparam logic [HOLD_W-1:0] HOLD_MAX = 20'hFFFFF;

	// Request kinds.
	localparam logic [1:0] KIND_CMD = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_INIT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HALF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWERUP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_FINAL = 3'd4;

	// Configuration reset values.
	localparam logic [9:0] RST_ENABLE_HALF = 10'd50;
	localparam logic [15:0] RST_SETTLE = 16'd2000;
	localparam logic [15:0] RST_INIT_STEP = 16'd10000;
	localparam logic [19:0] RST_POWERUP = 20'd100000;
	localparam logic [15:0] RST_INIT_FINAL = 16'd5000;

	// Event steps of the sequencer. An init request walks all of them; a byte
	// request enters at the last byte slot and walks its four events.
	localparam logic [STEP_W-1:0] STEP_POWERUP = 5'd0;
	localparam logic [STEP_W-1:0] STEP_NIB_LAST = 5'd8;
	localparam logic [STEP_W-1:0] STEP_BYTE_FIRST = 5'd9;
	localparam logic [STEP_W-1:0] STEP_BYTE_ONLY = 5'd21;
	localparam logic [STEP_W-1:0] STEP_FINAL = 5'd24;

	localparam logic [3:0] INIT_NIB = 4'h3;
	localparam logic [3:0] INIT_NIB_LAST = 4'h2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
	} req_t;

	typedef struct packed {
		logic reg_select;
		logic read_write;
		logic enable_line;
		logic [3:0] bus_nibble;
		logic [HOLD_W-1:0] hold_us;
		logic last;
	} evt_t;

	// Classified request as it travels through the queue.
	typedef struct packed {
		logic is_init;
		logic reg_select;
		logic [7:0] byte_value;
	} desc_t;

	typedef struct packed {
		logic [9:0] enable_half_us;
		logic [15:0] settle_us;
		logic [15:0] init_step_us;
		logic [19:0] powerup_us;
		logic [15:0] init_final_us;
	} cfg_t;

	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h28;
			2'd1: r = 8'h0C;
			2'd2: r = 8'h06;
			default: r = 8'h01;
		endcase
		return r;
	endfunction

	function automatic logic [HOLD_W-1:0] sat_add(input logic [HOLD_W-1:0] a,
			input logic [HOLD_W-1:0] b);
		logic [HOLD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[HOLD_W] ? HOLD_MAX : s[HOLD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/char_lcd_4bit_write_sequencer.sv =====
`default_nettype none
// Character LCD write sequencer for a 4-bit bus. Each request (command byte,
// data byte or init) is turned into a list of pin events on the result queue;
// each event gives the RS, RW, EN and D4..D7 levels and a hold time in
// microseconds, and the final event of a request has last set. A byte write
// gives four events, init gives twenty-five, and the unused request kind gives
// none. Pacing the pins in real time is left to the consumer of the events.
// A request is classified in the front end and passed through a short queue
// to the sequencer, which emits one event per clock while the result side
// keeps popping; the sequencer loads the next request from the queue only
// after the final event of the current one. The configuration channel is
// always ready, and its registers should only be written while no request is
// in flight.
module char_lcd_4bit_write_sequencer #(
	parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire clcd_pkg::req_t req,
	output logic empty,
	input wire logic pop,
	output clcd_pkg::evt_t evt,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [clcd_pkg::CFG_DATA_W-1:0] cfg_data
);

	clcd_pkg::cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_valid;
	logic q_pop;
	clcd_pkg::desc_t q_wr_desc;
	clcd_pkg::desc_t q_rd_desc;

	// Configuration writes take effect at once; wider data is truncated to the
	// register's width and writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_half_us <= clcd_pkg::RST_ENABLE_HALF;
			cfg_q.settle_us <= clcd_pkg::RST_SETTLE;
			cfg_q.init_step_us <= clcd_pkg::RST_INIT_STEP;
			cfg_q.powerup_us <= clcd_pkg::RST_POWERUP;
			cfg_q.init_final_us <= clcd_pkg::RST_INIT_FINAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				clcd_pkg::CFG_ENABLE_HALF: cfg_q.enable_half_us <= cfg_data[9:0];
				clcd_pkg::CFG_SETTLE: cfg_q.settle_us <= cfg_data[15:0];
				clcd_pkg::CFG_INIT_STEP: cfg_q.init_step_us <= cfg_data[15:0];
				clcd_pkg::CFG_POWERUP: cfg_q.powerup_us <= cfg_data[19:0];
				clcd_pkg::CFG_INIT_FINAL: cfg_q.init_final_us <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front end: takes each request transfer and classifies it.
	clcd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.q_push(q_push),
		.q_full(q_full),
		.q_desc(q_wr_desc)
	);

	// Short queue that decouples request intake from event generation.
	clcd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.full(q_full),
		.wr_desc(q_wr_desc),
		.valid(q_valid),
		.pop(q_pop),
		.rd_desc(q_rd_desc)
	);

	// Sequencer: walks the event steps of one request and registers each
	// event into the result slot.
	clcd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_desc(q_rd_desc),
		.empty(empty),
		.pop(pop),
		.evt(evt)
	);

endmodule
`default_nettype wire

// ===== rtl/clcd_front.sv =====
`default_nettype none
module clcd_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire clcd_pkg::req_t req,
	output logic q_push,
	input wire logic q_full,
	output clcd_pkg::desc_t q_desc
);

	logic valid_s1;
	clcd_pkg::desc_t desc_s1;
	logic accept;
	logic handoff;

	assign handoff = valid_s1 && !q_full;
	assign full = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1;
	assign q_desc = desc_s1;

	// Requests of the unused kind are taken and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= req.kind inside {clcd_pkg::KIND_CMD, clcd_pkg::KIND_DATA,
				clcd_pkg::KIND_INIT};
		end else if (handoff) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1.is_init <= (req.kind == clcd_pkg::KIND_INIT);
			desc_s1.reg_select <= (req.kind == clcd_pkg::KIND_DATA);
			desc_s1.byte_value <= req.byte_value;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/clcd_fifo.sv =====
`default_nettype none
module clcd_fifo #(
	parameter int unsigned DEPTH = clcd_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire clcd_pkg::desc_t wr_desc,
	output logic valid,
	input wire logic pop,
	output clcd_pkg::desc_t rd_desc
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	clcd_pkg::desc_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign do_wr = push && !full;
	assign do_rd = pop && valid;
	assign rd_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/clcd_back.sv =====
`default_nettype none
module clcd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire clcd_pkg::cfg_t cfg,
	input wire logic q_valid,
	output logic q_pop,
	input wire clcd_pkg::desc_t q_desc,
	output logic empty,
	input wire logic pop,
	output clcd_pkg::evt_t evt
);

	logic busy_q;
	logic out_valid_q;
	logic [clcd_pkg::STEP_W-1:0] step_q;
	clcd_pkg::desc_t desc_q;
	clcd_pkg::evt_t evt_q;
	clcd_pkg::evt_t ev;
	logic take;
	logic emit;
	logic [clcd_pkg::STEP_W-1:0] nib_idx;
	logic [clcd_pkg::STEP_W-1:0] byte_idx;
	logic [7:0] cur_byte;
	logic [clcd_pkg::HOLD_W-1:0] half;
	logic [clcd_pkg::HOLD_W-1:0] byte_end_hold;
	logic [clcd_pkg::HOLD_W-1:0] extra;

	assign take = !busy_q && q_valid;
	assign q_pop = take;
	assign emit = busy_q && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign evt = evt_q;

	assign nib_idx = (step_q - 1'b1) >> 1;
	assign byte_idx = step_q - clcd_pkg::STEP_BYTE_FIRST;
	assign cur_byte = desc_q.is_init ? clcd_pkg::init_cmd(byte_idx[3:2]) : desc_q.byte_value;
	assign half = clcd_pkg::HOLD_W'(cfg.enable_half_us);
	assign extra = (desc_q.is_init && step_q == clcd_pkg::STEP_FINAL)
		? clcd_pkg::HOLD_W'(cfg.init_final_us) : '0;
	assign byte_end_hold = clcd_pkg::sat_add(
		clcd_pkg::sat_add(half, clcd_pkg::HOLD_W'(cfg.settle_us)), extra);

	always_comb begin
		ev.reg_select = desc_q.reg_select;
		ev.read_write = 1'b0;
		ev.last = (step_q == clcd_pkg::STEP_FINAL);
		if (step_q == clcd_pkg::STEP_POWERUP) begin
			ev.reg_select = 1'b0;
			ev.enable_line = 1'b0;
			ev.bus_nibble = 4'h0;
			ev.hold_us = cfg.powerup_us;
		end else if (step_q <= clcd_pkg::STEP_NIB_LAST) begin
			// Single init nibbles: odd steps raise the strobe, even steps drop it.
			ev.enable_line = step_q[0];
			ev.bus_nibble = (nib_idx[1:0] == 2'd3) ? clcd_pkg::INIT_NIB_LAST
				: clcd_pkg::INIT_NIB;
			ev.hold_us = step_q[0] ? half
				: clcd_pkg::sat_add(half, clcd_pkg::HOLD_W'(cfg.init_step_us));
		end else begin
			ev.enable_line = !byte_idx[0];
			ev.bus_nibble = byte_idx[1] ? cur_byte[3:0] : cur_byte[7:4];
			ev.hold_us = (byte_idx[1:0] == 2'd3) ? byte_end_hold : half;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				step_q <= q_desc.is_init ? clcd_pkg::STEP_POWERUP : clcd_pkg::STEP_BYTE_ONLY;
			end else if (emit) begin
				step_q <= step_q + 1'b1;
				if (step_q == clcd_pkg::STEP_FINAL) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_q <= q_desc;
		end
		if (emit) begin
			evt_q <= ev;
		end
	end

endmodule
`default_nettype wire

// ===== sim/lcd_event_check_pkg.sv =====
package lcd_event_check_pkg;
	import clcd_pkg::*;

	// Commands issued at the end of the power-on sequence, in order.
	localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] LCD_CLEAR = 8'h01;

	class lcd_event_scoreboard;
		cfg_t timing;
		evt_t expected_events[$];
		int unsigned error_count;

		function new();
			timing.enable_half_us = 10'd50;
			timing.settle_us = 16'd2000;
			timing.init_step_us = 16'd10000;
			timing.powerup_us = 20'd100000;
			timing.init_final_us = 16'd5000;
			error_count = 0;
		endfunction

		function void write_setting(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_ENABLE_HALF: timing.enable_half_us = value[9:0];
				CFG_SETTLE: timing.settle_us = value[15:0];
				CFG_INIT_STEP: timing.init_step_us = value[15:0];
				CFG_POWERUP: timing.powerup_us = value[19:0];
				CFG_INIT_FINAL: timing.init_final_us = value[15:0];
				default: ;
			endcase
		endfunction

		// Hold times clip at the top of the 20-bit range instead of wrapping.
		function logic [HOLD_W-1:0] hold_sum(int unsigned a, int unsigned b);
			int unsigned total;
			total = a + b;
			return (total > HOLD_MAX) ? HOLD_MAX : total[HOLD_W-1:0];
		endfunction

		function void add_event(logic rs, logic en, logic [3:0] nibble,
				logic [HOLD_W-1:0] hold, logic last);
			evt_t e;
			e.reg_select = rs;
			e.read_write = 1'b0;
			e.enable_line = en;
			e.bus_nibble = nibble;
			e.hold_us = hold;
			e.last = last;
			expected_events.push_back(e);
		endfunction

		function void add_byte(logic rs, logic [7:0] value, logic [HOLD_W-1:0] extra,
				logic last);
			add_event(rs, 1'b1, value[7:4], timing.enable_half_us, 1'b0);
			add_event(rs, 1'b0, value[7:4], timing.enable_half_us, 1'b0);
			add_event(rs, 1'b1, value[3:0], timing.enable_half_us, 1'b0);
			add_event(rs, 1'b0, value[3:0],
				hold_sum(hold_sum(timing.enable_half_us, timing.settle_us), extra), last);
		endfunction

		function void note_request(req_t r);
			logic [3:0] nibble;
			case (r.kind)
				KIND_CMD, KIND_DATA: add_byte(r.kind == KIND_DATA, r.byte_value, '0, 1'b1);
				KIND_INIT: begin
					add_event(1'b0, 1'b0, 4'h0, timing.powerup_us, 1'b0);
					for (int n = 0; n < 4; n++) begin
						nibble = (n == 3) ? INIT_NIB_LAST : INIT_NIB;
						add_event(1'b0, 1'b1, nibble, timing.enable_half_us, 1'b0);
						add_event(1'b0, 1'b0, nibble,
							hold_sum(timing.enable_half_us, timing.init_step_us), 1'b0);
					end
					add_byte(1'b0, LCD_FUNCTION_SET, '0, 1'b0);
					add_byte(1'b0, LCD_DISPLAY_ON, '0, 1'b0);
					add_byte(1'b0, LCD_ENTRY_MODE, '0, 1'b0);
					add_byte(1'b0, LCD_CLEAR, timing.init_final_us, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [HOLD_W-1:0] want,
				logic [HOLD_W-1:0] got);
			if (got !== want) begin
				error_count++;
				$display("%0t: event field %s differs: expected %0h, got %0h",
					$time, name, want, got);
			end
		endfunction

		function void check_event(evt_t got);
			evt_t want;
			if (expected_events.size() == 0) begin
				error_count++;
				$display("%0t: event arrived with none pending: expected nothing, got %h",
					$time, got);
				return;
			end
			want = expected_events.pop_front();
			compare_field("reg_select", want.reg_select, got.reg_select);
			compare_field("read_write", want.read_write, got.read_write);
			compare_field("enable_line", want.enable_line, got.enable_line);
			compare_field("bus_nibble", want.bus_nibble, got.bus_nibble);
			compare_field("hold_us", want.hold_us, got.hold_us);
			compare_field("last", want.last, got.last);
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction
	endclass

endpackage

// ===== sim/char_lcd_4bit_write_sequencer_tb.sv =====
module char_lcd_4bit_write_sequencer_tb;
	import clcd_pkg::*;
	import lcd_event_check_pkg::*;

	// The fourth request kind is unused; the block must swallow it silently.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned RANDOM_REQUESTS = 150;
	// Calm stretch at the end of the run, in requests.
	localparam int unsigned CALM_REQUESTS = 40;
	// Wait after the last expected event; it outlasts the longest request inside
	// the block, so the block is surely idle again when it ends.
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	evt_t evt;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// When set, neither the request side nor the event side inserts idle cycles.
	bit calm = 1'b0;
	int unsigned requests_sent = 0;
	int unsigned cycle_count = 0;
	lcd_event_scoreboard sb;

	char_lcd_4bit_write_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.evt(evt),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing event ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("char_lcd_4bit_write_sequencer: mismatch");
			$finish;
		end
	end

	// Push one request. Every task here starts and ends on a falling edge, and
	// push is left high afterwards so that back-to-back transfers never lower
	// and raise it in the same time step. An optional idle burst comes first.
	task automatic send_request(logic [1:0] kind, logic [7:0] value);
		req_t r;
		r.kind = kind;
		r.byte_value = value;
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		// The transfer happened at this edge, so the expected events are due now.
		sb.note_request(r);
		if (kind != KIND_UNUSED) requests_sent++;
		@(negedge clk);
	endtask

	// One register write. cfg_valid stays high; the caller lowers it after the
	// whole batch of writes.
	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_setting(index, value);
		@(negedge clk);
	endtask

	// Half of the time, garbage goes above the register's width; the block
	// must drop those bits.
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] value,
			int unsigned width);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom) << width;
		return ($urandom_range(0, 1) == 1) ? (value | junk) : value;
	endfunction

	// Writes all five timing registers, with one write to an index that does
	// not exist placed either before or after them.
	task automatic program_timing(cfg_t t);
		bit stray_first;
		logic [CFG_IDX_W-1:0] stray_index;
		stray_first = $urandom_range(0, 1);
		stray_index = CFG_IDX_W'($urandom_range(CFG_INIT_FINAL + 1, (1 << CFG_IDX_W) - 1));
		if (stray_first) write_register(stray_index, CFG_DATA_W'($urandom));
		write_register(CFG_ENABLE_HALF, with_junk(t.enable_half_us, 10));
		write_register(CFG_SETTLE, with_junk(t.settle_us, 16));
		write_register(CFG_INIT_STEP, with_junk(t.init_step_us, 16));
		write_register(CFG_POWERUP, t.powerup_us);
		write_register(CFG_INIT_FINAL, with_junk(t.init_final_us, 16));
		if (!stray_first) write_register(stray_index, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Lowers push, waits until every expected event has been popped, then gives
	// the block time to finish any swallowed request before the next writes.
	task automatic wait_idle();
		push <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Each timing value is zero, its maximum or random, so the extremes come
	// up often in combination.
	function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned width);
		logic [CFG_DATA_W-1:0] top;
		top = CFG_DATA_W'((1 << width) - 1);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return top;
			default: return CFG_DATA_W'($urandom) & top;
		endcase
	endfunction

	function automatic cfg_t random_timing();
		cfg_t t;
		t.enable_half_us = 10'(pick_value(10));
		t.settle_us = 16'(pick_value(16));
		t.init_step_us = 16'(pick_value(16));
		t.powerup_us = 20'(pick_value(20));
		t.init_final_us = 16'(pick_value(16));
		return t;
	endfunction

	// Mostly byte writes, with init now and then and a few unused-kind requests.
	task automatic send_random_request();
		int unsigned roll;
		logic [1:0] kind;
		roll = $urandom_range(0, 99);
		if (roll < 42) kind = KIND_CMD;
		else if (roll < 84) kind = KIND_DATA;
		else if (roll < 94) kind = KIND_INIT;
		else kind = KIND_UNUSED;
		send_request(kind, 8'($urandom_range(0, 255)));
	endtask

	// Event side: pops the oldest event whenever one is waiting, with random
	// stall bursts unless the run is in its calm stretch.
	initial begin : event_sink
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (!empty) sb.check_event(evt);
		end
	end

	initial begin : stimulus
		int unsigned batch;
		int unsigned target;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset timing values: byte extremes on both register selects, init with
		// an arbitrary byte, and the unused kind with both byte extremes.
		send_request(KIND_CMD, 8'h00);
		send_request(KIND_CMD, 8'hFF);
		send_request(KIND_DATA, 8'h00);
		send_request(KIND_DATA, 8'hFF);
		send_request(KIND_DATA, 8'hA5);
		send_request(KIND_CMD, 8'h5A);
		send_request(KIND_INIT, 8'h00);
		send_request(KIND_UNUSED, 8'hFF);
		send_request(KIND_UNUSED, 8'h00);
		send_request(KIND_INIT, 8'hFF);
		wait_idle();

		// Every register at its maximum, the largest possible hold sums.
		program_timing('1);
		send_request(KIND_INIT, 8'h3C);
		send_request(KIND_CMD, 8'h3C);
		send_request(KIND_DATA, 8'hC3);
		send_request(KIND_UNUSED, 8'h81);
		wait_idle();

		// Every register at zero.
		program_timing('0);
		send_request(KIND_INIT, 8'h00);
		send_request(KIND_DATA, 8'hF0);
		send_request(KIND_CMD, 8'h0F);
		wait_idle();

		// Random phases, each with fresh timing values. The last phase runs
		// without idle bursts on either side.
		target = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < target) begin
			if (requests_sent + CALM_REQUESTS >= target) calm = 1'b1;
			program_timing(random_timing());
			batch = calm ? CALM_REQUESTS : $urandom_range(15, 40);
			repeat (batch) begin
				if (requests_sent < target) send_random_request();
			end
			wait_idle();
		end

		if (sb.error_count == 0) begin
			$display("char_lcd_4bit_write_sequencer: match");
		end else begin
			$display("char_lcd_4bit_write_sequencer: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/clcd_pkg.sv
rtl/clcd_front.sv
rtl/clcd_fifo.sv
rtl/clcd_back.sv
rtl/char_lcd_4bit_write_sequencer.sv
sim/lcd_event_check_pkg.sv
sim/char_lcd_4bit_write_sequencer_tb.sv
